// File: rtl/sorted_priority_queue_core_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms for the queue core.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Codes, entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_RSVD  = 2'd3;

   typedef struct packed {
      logic signed [15:0] pri;
      logic signed [31:0] val;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic start_enq;
      logic read_prev;
      logic shift;
      logic insert;
      logic read_head;
      logic pop;
      logic set_full;
      logic set_empty;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic op;
      logic full;
      logic empty;
      logic k_zero;
      logic rd_less;
   } sts_type;

endpackage

// File: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences one transaction at a time and owns the response valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  spq_pkg::sts_type sts,
   output spq_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_DQWAIT = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.op == spq_pkg::OP_ENQUEUE) begin
               if (sts.full) begin
                  cmd.set_full = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  cmd.start_enq = 1'b1;
                  state_in      = ST_SCAN;
               end
            end else begin
               if (sts.empty) begin
                  cmd.set_empty = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  cmd.read_head = 1'b1;
                  state_in      = ST_DQWAIT;
               end
            end
         end
         ST_SCAN: begin
            if (sts.k_zero) begin
               cmd.insert = 1'b1;
               state_in   = ST_RESP;
            end else begin
               cmd.read_prev = 1'b1;
               state_in      = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sts.rd_less) begin
               cmd.shift = 1'b1;
               state_in  = ST_SCAN;
            end else begin
               cmd.insert = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_DQWAIT: begin
            cmd.pop  = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Circular entry memory, head/count pointers, insertion cursor, result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_operation,
   input  logic signed [31:0] req_item_value,
   input  logic signed [15:0] req_item_priority,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_occupancy,
   input  spq_pkg::cmd_type   cmd,
   output spq_pkg::sts_type   sts
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

   spq_pkg::entry_type mem [CAPACITY];

   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      cursor_ff, cursor_in;
   logic [CW-1:0]      k_ff, k_in;
   logic               op_ff;
   logic signed [31:0] val_ff;
   logic signed [15:0] pri_ff;
   spq_pkg::entry_type rd_ff;
   logic [1:0]         res_status_ff, res_status_in;
   logic signed [31:0] res_value_ff, res_value_in;
   logic signed [31:0] out_value_ff;
   logic [1:0]         out_status_ff;
   logic [4:0]         out_occ_ff;

   logic [AW-1:0]      cursor_prev;
   logic [AW-1:0]      head_next;
   logic [AW:0]        tail_sum;
   logic [AW-1:0]      tail;
   logic [CW+4:0]      occ_wide;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   spq_pkg::entry_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   assign cursor_prev = (cursor_ff == '0) ? LAST : cursor_ff - AW'(1);
   assign head_next   = (head_ff == LAST) ? '0 : head_ff + AW'(1);
   assign tail_sum    = {1'b0, head_ff} + (AW+1)'(count_ff);
   assign tail        = (tail_sum >= (AW+1)'(CAPACITY)) ?
                        AW'(tail_sum - (AW+1)'(CAPACITY)) : tail_sum[AW-1:0];

   assign sts.op      = op_ff;
   assign sts.full    = (count_ff == CW'(CAPACITY));
   assign sts.empty   = (count_ff == '0);
   assign sts.k_zero  = (k_ff == '0);
   assign sts.rd_less = (rd_ff.pri < pri_ff);

   // memory ports
   always_comb begin
      wr_en   = cmd.shift || cmd.insert;
      wr_addr = cursor_ff;
      if (cmd.shift) begin
         wr_data = rd_ff;
      end else begin
         wr_data.pri = pri_ff;
         wr_data.val = val_ff;
      end
      rd_en   = cmd.read_prev || cmd.read_head;
      rd_addr = cmd.read_head ? head_ff : cursor_prev;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // pointer and result updates
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      if (cmd.start_enq) begin
         cursor_in = tail;
         k_in      = count_ff;
      end
      if (cmd.shift) begin
         cursor_in = cursor_prev;
         k_in      = k_ff - CW'(1);
      end
      if (cmd.insert) begin
         count_in      = count_ff + CW'(1);
         res_status_in = spq_pkg::STATUS_OK;
         res_value_in  = '0;
      end
      if (cmd.pop) begin
         head_in       = head_next;
         count_in      = count_ff - CW'(1);
         res_status_in = spq_pkg::STATUS_OK;
         res_value_in  = rd_ff.val;
      end
      if (cmd.set_full) begin
         res_status_in = spq_pkg::STATUS_FULL;
         res_value_in  = '0;
      end
      if (cmd.set_empty) begin
         res_status_in = spq_pkg::STATUS_EMPTY;
         res_value_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign occ_wide = {5'd0, count_ff};

   always_ff @(posedge clock) begin
      cursor_ff     <= cursor_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      if (cmd.load_req) begin
         op_ff  <= req_operation;
         val_ff <= req_item_value;
         pri_ff <= req_item_priority;
      end
      if (cmd.load_rsp) begin
         out_value_ff  <= res_value_ff;
         out_status_ff <= res_status_ff;
         out_occ_ff    <= occ_wide[4:0];
      end
   end

   assign rsp_out_value = out_value_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_occupancy = out_occ_ff;

endmodule

// File: rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded max-priority queue, sorted storage, FIFO order among equals.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, item_value, item_priority
//   rsp      out        rsp_valid/rsp_stall  out_value, status, occupancy
//
// One transaction is worked at a time. Full enqueue and empty dequeue go
// from accept through the decide state to response load; a dequeue reads
// the head, then pops it. An enqueue that moves s entries toward the tail
// takes a scan and a compare step per entry moved, since the entry memory
// has a single read and single write port (one shift is a read then a write).
// Reset is synchronous, active high; it empties the queue, no memory sweep.
// req_stall is high from accept until the response is loaded; a stalled
// response holds in the output register while the next request is taken.
//
`timescale 1ns / 1ps

`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [31:0] req_item_value,
   input  logic signed [15:0] req_item_priority,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_occupancy
);

   spq_pkg::cmd_type cmd;
   spq_pkg::sts_type sts;

   // sequencer: accept, classify, scan/shift or pop, respond
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // circular entry store: head holds the oldest highest priority entry,
   // enqueue walks back from the tail moving lower priorities up one slot
   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .cmd               (cmd),
      .sts               (sts)
   );

   // response register never overwritten while a stalled one waits
   `SPQ_ASSERT_NOW(a_rsp_no_overwrite, clock, reset, cmd.load_rsp, !rsp_valid || !rsp_stall)
   // busy right after a transaction is accepted
   `SPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // no insert or shift into a full queue
   `SPQ_ASSERT_NOW(a_no_write_full, clock, reset, cmd.insert || cmd.shift, !sts.full)
   // reserved status code never presented
   `SPQ_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status != spq_pkg::STATUS_RSVD)

endmodule
